FILE: src/spcf_pkg.sv
// shared constants, types and tables for the segment pair crossing finder
package spcf_pkg;

    localparam int MAX_STICKS   = 64;
    localparam int SLOT_W       = $clog2(MAX_STICKS);
    localparam int CNT_W        = $clog2(MAX_STICKS + 1);
    localparam int MAX_RES      = 63;
    localparam int RES_W        = 6;
    localparam int CORDIC_STEPS = 14;
    localparam int STEP_W       = 4;
    localparam int POS_W        = 18;
    localparam int ANG_W        = 16;
    localparam int LAB_W        = 16;
    localparam int LEN_W        = 17;
    localparam int TRIG_W       = 19;
    localparam int ZW           = 18;
    localparam int DIFF_W       = 19;
    localparam int PROD_W       = 38;
    localparam int ACC_W        = 40;
    localparam int DIST_W       = 17;
    localparam int NSLOT_W      = 7;
    localparam int ENTRY_W      = 2 * POS_W + ANG_W + LAB_W;
    localparam int IN_DATA_W    = 72;
    localparam int OUT_DATA_W   = 80;

    localparam logic [NSLOT_W-1:0] NOT_STORED  = NSLOT_W'(MAX_STICKS);
    localparam logic [LEN_W-1:0]   LEN_RESET   = 17'd65536;
    localparam logic [TRIG_W-1:0]  CORDIC_GAIN = 19'd39797;

    // stick kinds
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cn;
        logic signed [TRIG_W-1:0] sn;
        logic signed [TRIG_W-1:0] co;
        logic signed [TRIG_W-1:0] so;
        logic signed [DIFF_W-1:0] bx;
        logic signed [DIFF_W-1:0] by;
    } t_sol_req;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] d_old;
        logic [DIST_W-1:0] d_new;
    } t_sol_res;

    // atan(2^-i) in units of 1/65536 turn
    function automatic logic [13:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [13:0] v;
        case (i)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/spcf_cordic.sv
// iterative rotation cordic giving cosine and sine of a turn-fraction angle
module spcf_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [spcf_pkg::ANG_W-1:0]          i_angle,
    output logic                                o_done,
    output logic signed [spcf_pkg::TRIG_W-1:0]  o_cos,
    output logic signed [spcf_pkg::TRIG_W-1:0]  o_sin
);

    logic                               r_busy;
    logic [spcf_pkg::STEP_W-1:0]        r_step;
    logic signed [spcf_pkg::TRIG_W-1:0] r_x, r_y, r_cos, r_sin;
    logic signed [spcf_pkg::ZW-1:0]     r_z;
    logic                               r_flip, r_done;

    logic signed [spcf_pkg::TRIG_W-1:0] n_x, n_y;
    logic signed [spcf_pkg::ZW-1:0]     n_z, z0, atz;
    logic                               flip0;

    // fold into the half turn around zero
    always_comb begin
        flip0 = 1'b0;
        if (i_angle >= 16'd16384 && i_angle < 16'd49152) begin
            z0    = $signed({2'b00, i_angle}) - 18'sd32768;
            flip0 = 1'b1;
        end else if (i_angle >= 16'd49152) begin
            z0 = $signed({2'b00, i_angle}) - 18'sd65536;
        end else begin
            z0 = $signed({2'b00, i_angle});
        end
    end

    always_comb begin
        atz = $signed({4'b0000, spcf_pkg::atan_turn(r_step)});
        if (r_z >= 0) begin
            n_x = r_x - (r_y >>> r_step);
            n_y = r_y + (r_x >>> r_step);
            n_z = r_z - atz;
        end else begin
            n_x = r_x + (r_y >>> r_step);
            n_y = r_y - (r_x >>> r_step);
            n_z = r_z + atz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= !i_start && r_busy
                      && (r_step == spcf_pkg::STEP_W'(spcf_pkg::CORDIC_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_x    <= spcf_pkg::CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= z0;
                r_flip <= flip0;
            end else if (r_busy) begin
                r_x    <= n_x;
                r_y    <= n_y;
                r_z    <= n_z;
                r_step <= r_step + 1'b1;
                if (r_step == spcf_pkg::STEP_W'(spcf_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_cos  <= r_flip ? -n_x : n_x;
                    r_sin  <= r_flip ? -n_y : n_y;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

FILE: src/spcf_solver.sv
// shared multiplier and restoring divider that solve one stick pair
module spcf_solver (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  spcf_pkg::t_sol_req          i_req,
    input  logic [spcf_pkg::LEN_W-1:0]  i_len,
    output logic                        o_done,
    output spcf_pkg::t_sol_res          o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_NORM = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIVO = 3'd4;
    localparam logic [2:0] S_DIVN = 3'd5;

    localparam int DIV_LAST = spcf_pkg::DIST_W - 1;

    logic [2:0]                          r_state;
    logic [4:0]                          r_step;
    spcf_pkg::t_sol_req                  r_req;
    logic signed [spcf_pkg::PROD_W-1:0]  r_prod;
    logic signed [spcf_pkg::ACC_W-1:0]   r_det, r_numo, r_numn, prod_x;
    logic [spcf_pkg::ACC_W-1:0]          r_rem, div_t, twodet;
    logic [spcf_pkg::DIST_W-1:0]         r_q, r_do, n_q;
    logic                                div_ge, r_done;
    logic                                chk_fail, done_now;
    logic signed [spcf_pkg::TRIG_W-1:0]  ma;
    logic signed [spcf_pkg::DIFF_W-1:0]  mb;
    spcf_pkg::t_sol_res                  r_res;

    // operand selection for the one multiplier
    always_comb begin
        case (r_step)
            5'd0:    begin ma = r_req.cn; mb = r_req.so; end
            5'd1:    begin ma = r_req.co; mb = r_req.sn; end
            5'd2:    begin ma = r_req.sn; mb = r_req.bx; end
            5'd3:    begin ma = r_req.cn; mb = r_req.by; end
            5'd4:    begin ma = r_req.so; mb = r_req.bx; end
            default: begin ma = r_req.co; mb = r_req.by; end
        endcase
    end

    assign prod_x = {{(spcf_pkg::ACC_W - spcf_pkg::PROD_W){r_prod[spcf_pkg::PROD_W-1]}}, r_prod};
    assign twodet = {r_det[spcf_pkg::ACC_W-2:0], 1'b0};

    // quotient of 2^17 or more can never pass the length test
    assign chk_fail = r_numo <= 0 || r_numn <= 0 || $unsigned(r_numo) >= twodet
                      || $unsigned(r_numn) >= twodet;
    assign done_now = (r_state == S_NORM && r_det == '0)
                      || (r_state == S_CHK && chk_fail)
                      || (r_state == S_DIVN && r_step == 5'(DIV_LAST));

    // one restoring divide step
    always_comb begin
        div_t  = (r_step == 5'd0) ? r_rem : {r_rem[spcf_pkg::ACC_W-2:0], 1'b0};
        div_ge = div_t >= $unsigned(r_det);
        n_q    = {r_q[spcf_pkg::DIST_W-2:0], div_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_done <= done_now;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req;
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= ma * mb;
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        5'd1:    r_det  <= prod_x;
                        5'd2:    r_det  <= r_det - prod_x;
                        5'd3:    r_numo <= prod_x;
                        5'd4:    r_numo <= r_numo - prod_x;
                        5'd5:    r_numn <= prod_x;
                        5'd6:    r_numn <= r_numn - prod_x;
                        default: ;
                    endcase
                    if (r_step == 5'd6) r_state <= S_NORM;
                end
                S_NORM: begin
                    if (r_det == '0) begin
                        r_res.hit <= 1'b0;
                        r_state   <= S_IDLE;
                    end else begin
                        if (r_det < 0) begin
                            r_det  <= -r_det;
                            r_numo <= -r_numo;
                            r_numn <= -r_numn;
                        end
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (chk_fail) begin
                        r_res.hit <= 1'b0;
                        r_state   <= S_IDLE;
                    end else begin
                        r_rem   <= $unsigned(r_numo);
                        r_q     <= '0;
                        r_step  <= '0;
                        r_state <= S_DIVO;
                    end
                end
                S_DIVO: begin
                    if (r_step == 5'(DIV_LAST)) begin
                        r_do    <= n_q;
                        r_rem   <= $unsigned(r_numn);
                        r_q     <= '0;
                        r_step  <= '0;
                        r_state <= S_DIVN;
                    end else begin
                        r_rem  <= div_ge ? div_t - $unsigned(r_det) : div_t;
                        r_q    <= n_q;
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DIVN: begin
                    r_rem  <= div_ge ? div_t - $unsigned(r_det) : div_t;
                    r_q    <= n_q;
                    r_step <= r_step + 1'b1;
                    if (r_step == 5'(DIV_LAST)) begin
                        r_res.hit   <= (r_do != '0) && (r_do < i_len)
                                       && (n_q != '0) && (n_q < i_len);
                        r_res.d_old <= r_do;
                        r_res.d_new <= n_q;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: src/segment_pair_crossing_finder.sv
// top level: stick store, pair sequencer and crossing record output
//
//  channel   dir  handshake                 payload
//  s stream  in   i_s_tvalid / o_s_tready   tdata label,pos_x,pos_y,angle; tuser kind
//  m stream  out  o_m_tvalid / i_m_tready   tdata slots,labels,dists; tuser full; tlast
//  config    in   i_cfg_we                  i_cfg_wdata stick_length
//
//  one stick at a time; ready is low from an add beat until its records are handed off
//  add beat: own cordic, then per stored stick a read and check, skipped on equal label
//  and angle, else a cordic of the stored angle and the solver, which drops parallel
//  pairs and sign or range failures; an emit step per record, then a closing end step;
//  clear beat resets the stick count; output stall holds the sequencer in emit or end
//  synchronous active-low reset, store contents not cleared
module segment_pair_crossing_finder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // label[15:0], pos_x[33:16], pos_y[51:34], angle[67:52], zero pad
    input  logic [spcf_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // kind
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // old_slot[5:0], new_slot[12:6], old_label[28:13], new_label[44:29],
    // dist_old[61:45], dist_new[78:62], zero pad
    output logic [spcf_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // store_full
    output logic                               o_m_tuser,
    output logic                               o_m_tlast,
    input  logic                               i_cfg_we,
    input  logic [spcf_pkg::LEN_W-1:0]         i_cfg_wdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TRIGN = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_TRIGO = 3'd4;
    localparam logic [2:0] S_SOLVE = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;
    localparam logic [2:0] S_END   = 3'd7;

    logic [2:0]                         r_state;
    logic [spcf_pkg::LEN_W-1:0]         r_len;
    logic [spcf_pkg::CNT_W-1:0]         r_cnt, r_k, k_nxt;
    logic [spcf_pkg::RES_W-1:0]         r_n;
    logic                               r_full;
    logic [spcf_pkg::LAB_W-1:0]         r_label;
    logic [spcf_pkg::ANG_W-1:0]         r_angle;
    logic signed [spcf_pkg::POS_W-1:0]  r_nx, r_ny;
    logic signed [spcf_pkg::TRIG_W-1:0] r_cn, r_sn;
    spcf_pkg::t_sol_res                 r_hit;

    // stick store, one entry per slot: label, angle, y, x
    logic [spcf_pkg::ENTRY_W-1:0]       mem [spcf_pkg::MAX_STICKS];
    logic [spcf_pkg::ENTRY_W-1:0]       r_rd;
    logic                               mem_we;

    logic signed [spcf_pkg::POS_W-1:0]  rd_x, rd_y;
    logic [spcf_pkg::ANG_W-1:0]         rd_angle;
    logic [spcf_pkg::LAB_W-1:0]         rd_label;

    // pending record waits until we know whether it is the final one
    logic                               r_pv;
    logic [spcf_pkg::OUT_DATA_W-1:0]    r_pend;
    logic                               r_ovalid, r_ouser, r_olast;
    logic [spcf_pkg::OUT_DATA_W-1:0]    r_odata;
    logic                               out_free, out_load;

    logic                               s_acc;
    logic                               c_start, c_done;
    logic [spcf_pkg::ANG_W-1:0]         c_angle;
    logic signed [spcf_pkg::TRIG_W-1:0] c_cos, c_sin;
    logic                               sol_start, sol_done;
    spcf_pkg::t_sol_req                 sol_req;
    spcf_pkg::t_sol_res                 sol_res;
    logic [spcf_pkg::NSLOT_W-1:0]       new_slot;
    logic [spcf_pkg::OUT_DATA_W-1:0]    rec;
    logic                               skip_pair, more_k;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_free   = !r_ovalid || i_m_tready;
    // pending record moves to the output register
    assign out_load   = (r_state == S_EMIT || r_state == S_END) && r_pv && out_free;

    assign rd_x     = r_rd[spcf_pkg::POS_W-1:0];
    assign rd_y     = r_rd[2*spcf_pkg::POS_W-1:spcf_pkg::POS_W];
    assign rd_angle = r_rd[2*spcf_pkg::POS_W+spcf_pkg::ANG_W-1:2*spcf_pkg::POS_W];
    assign rd_label = r_rd[spcf_pkg::ENTRY_W-1:2*spcf_pkg::POS_W+spcf_pkg::ANG_W];

    assign k_nxt     = r_k + 1'b1;
    assign more_k    = k_nxt < r_cnt;
    assign skip_pair = (rd_label == r_label) && (rd_angle == r_angle);
    assign new_slot  = r_full ? spcf_pkg::NOT_STORED : r_cnt;

    // cordic is started for the incoming angle on accept, for a stored one after read
    assign c_start = (s_acc && i_s_tuser == spcf_pkg::KIND_ADD)
                     || (r_state == S_CHK && !skip_pair);
    assign c_angle = (r_state == S_IDLE) ? i_s_tdata[67:52] : rd_angle;

    assign sol_start  = (r_state == S_TRIGO) && c_done;
    assign sol_req.cn = r_cn;
    assign sol_req.sn = r_sn;
    assign sol_req.co = c_cos;
    assign sol_req.so = c_sin;
    assign sol_req.bx = {rd_x[spcf_pkg::POS_W-1], rd_x} - {r_nx[spcf_pkg::POS_W-1], r_nx};
    assign sol_req.by = {rd_y[spcf_pkg::POS_W-1], rd_y} - {r_ny[spcf_pkg::POS_W-1], r_ny};

    assign rec = {1'b0, r_hit.d_new, r_hit.d_old, r_label, rd_label, new_slot,
                  r_k[spcf_pkg::SLOT_W-1:0]};

    assign mem_we = (r_state == S_END) && !r_full && (!r_pv || out_free);

    spcf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_angle (c_angle),
        .o_done  (c_done),
        .o_cos   (c_cos),
        .o_sin   (c_sin)
    );

    spcf_solver u_solver (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sol_start),
        .i_req   (sol_req),
        .i_len   (r_len),
        .o_done  (sol_done),
        .o_res   (sol_res)
    );

    // store port: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[r_cnt[spcf_pkg::SLOT_W-1:0]] <= {r_label, r_angle, r_ny, r_nx};
        r_rd <= mem[r_k[spcf_pkg::SLOT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= spcf_pkg::LEN_RESET;
            r_cnt    <= '0;
            r_k      <= '0;
            r_n      <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_len <= i_cfg_wdata;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        if (i_s_tuser == spcf_pkg::KIND_CLEAR) begin
                            r_cnt <= '0;
                        end else begin
                            r_label <= i_s_tdata[15:0];
                            r_nx    <= i_s_tdata[33:16];
                            r_ny    <= i_s_tdata[51:34];
                            r_angle <= i_s_tdata[67:52];
                            r_full  <= r_cnt >= spcf_pkg::CNT_W'(spcf_pkg::MAX_STICKS);
                            r_k     <= '0;
                            r_n     <= '0;
                            r_state <= S_TRIGN;
                        end
                    end
                end
                S_TRIGN: begin
                    if (c_done) begin
                        r_cn    <= c_cos;
                        r_sn    <= c_sin;
                        r_state <= (r_cnt == '0) ? S_END : S_RD;
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (skip_pair) begin
                        r_k     <= k_nxt;
                        r_state <= more_k ? S_RD : S_END;
                    end else begin
                        r_state <= S_TRIGO;
                    end
                end
                S_TRIGO: begin
                    if (c_done) r_state <= S_SOLVE;
                end
                S_SOLVE: begin
                    if (sol_done) begin
                        r_hit <= sol_res;
                        if (sol_res.hit) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_k     <= k_nxt;
                            r_state <= more_k ? S_RD : S_END;
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_pv || out_free) begin
                        if (r_pv) begin
                            r_odata  <= r_pend;
                            r_ouser  <= r_full;
                            r_olast  <= 1'b0;
                        end
                        r_pv   <= 1'b1;
                        r_pend <= rec;
                        r_n    <= r_n + 1'b1;
                        // record cap reached: this one closes the item
                        if (r_n == spcf_pkg::RES_W'(spcf_pkg::MAX_RES - 1)) begin
                            r_state <= S_END;
                        end else begin
                            r_k     <= k_nxt;
                            r_state <= more_k ? S_RD : S_END;
                        end
                    end
                end
                S_END: begin
                    if (!r_pv || out_free) begin
                        if (r_pv) begin
                            r_odata  <= r_pend;
                            r_ouser  <= r_full;
                            r_olast  <= 1'b1;
                            r_pv     <= 1'b0;
                        end
                        if (!r_full) r_cnt <= r_cnt + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
    assign o_m_tlast  = r_olast;

endmodule

FILE: src/spcf_checker.sv
// port-level checks for the crossing finder and their bind
module spcf_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               o_s_tready,
    input  logic                               i_s_tuser,
    input  logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [spcf_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input  logic                               o_m_tuser,
    input  logic                               o_m_tlast
);

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast))
        else $error("output beat changed under stall");

    // an add beat makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == spcf_pkg::KIND_ADD |=> !o_s_tready)
        else $error("ready stayed high after add beat");

    // full flag agrees with the unstored slot code
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser == (o_m_tdata[12:6] == spcf_pkg::NOT_STORED))
        else $error("store_full and new_slot disagree");

    // distances are never zero in a record
    a_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[61:45] != '0 && o_m_tdata[78:62] != '0)
        else $error("zero crossing distance");

endmodule

bind segment_pair_crossing_finder spcf_checker u_spcf_checker (.*);

FILE: test/segment_pair_crossing_finder_tb.sv
// testbench for the segment pair crossing finder: stick stream in, crossing records out
`timescale 1ns / 1ps

module segment_pair_crossing_finder_tb;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  DRAIN_WAIT  = 5000;   // longer than a full-store add beat with no records
    localparam int  HOLD_CYCLES = 3000;

    typedef struct {
        logic                                  kind;
        logic [spcf_pkg::LAB_W-1:0]            label;
        logic signed [spcf_pkg::POS_W-1:0]     px;
        logic signed [spcf_pkg::POS_W-1:0]     py;
        logic [spcf_pkg::ANG_W-1:0]            angle;
    } t_stick;

    typedef struct packed {
        logic [spcf_pkg::SLOT_W-1:0]  old_slot;
        logic [spcf_pkg::NSLOT_W-1:0] new_slot;
        logic [spcf_pkg::LAB_W-1:0]   old_label;
        logic [spcf_pkg::LAB_W-1:0]   new_label;
        logic [spcf_pkg::DIST_W-1:0]  d_old;
        logic [spcf_pkg::DIST_W-1:0]  d_new;
        logic                         full;
        logic                         last;
    } t_crossing;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [spcf_pkg::IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                            i_s_tuser = 1'b0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [spcf_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                            o_m_tuser;
    logic                            o_m_tlast;
    logic                            i_cfg_we = 1'b0;
    logic [spcf_pkg::LEN_W-1:0]      i_cfg_wdata = '0;

    segment_pair_crossing_finder u_top (.*);

    always #1 i_clk = ~i_clk;

    // shadow of the block's store and register
    longint                      sh_x [spcf_pkg::MAX_STICKS];
    longint                      sh_y [spcf_pkg::MAX_STICKS];
    logic [spcf_pkg::ANG_W-1:0]  sh_angle [spcf_pkg::MAX_STICKS];
    logic [spcf_pkg::LAB_W-1:0]  sh_label [spcf_pkg::MAX_STICKS];
    int                          sh_count = 0;
    longint                      sh_length = 65536;

    t_stick    stick_q[$];
    t_stick    cur_stick;
    t_crossing crossing_q[$];

    int  errors = 0;
    int  n_records = 0;
    int  n_adds = 0;
    int  n_clears = 0;
    int  n_full_records = 0;
    int  n_capped = 0;
    int  cycles = 0;
    bit  idle_en = 1'b1;
    bit  hold_req = 1'b0;
    logic s_taken = 1'b0;

    // 14-step cordic, floor shifts, folded into the half turn around zero
    task automatic cordic(input logic [spcf_pkg::ANG_W-1:0] ang, output longint c,
                          output longint s);
        longint z, x, y, dx, dy;
        bit     flip;
        longint atab [spcf_pkg::CORDIC_STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163,
                                                   81, 41, 20, 10, 5, 3, 1};
        z = ang;
        flip = 1'b0;
        x = 39797;
        y = 0;
        if (z >= 16384 && z < 49152) begin
            z -= 32768;
            flip = 1'b1;
        end else if (z >= 49152) begin
            z -= 65536;
        end
        for (int i = 0; i < spcf_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atab[i];
            end else begin
                x += dx;
                y -= dy;
                z += atab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // compute the crossings of a newly accepted stick and update the shadow store
    task automatic find_crossings(input t_stick st);
        longint    cn, sn, co, so, det, bx, by, num_o, num_n, d_o, d_n, nx, ny;
        bit        full;
        int        slot, n;
        t_crossing rec;
        if (st.kind == spcf_pkg::KIND_CLEAR) begin
            sh_count = 0;
            n_clears++;
            return;
        end
        n_adds++;
        nx = st.px;
        ny = st.py;
        full = (sh_count >= spcf_pkg::MAX_STICKS);
        slot = full ? spcf_pkg::MAX_STICKS : sh_count;
        n = 0;
        cordic(st.angle, cn, sn);
        for (int k = 0; k < sh_count && n < spcf_pkg::MAX_RES; k++) begin
            // same stick seen twice (periodic ghost) is not a crossing
            if (sh_label[k] == st.label && sh_angle[k] == st.angle) continue;
            cordic(sh_angle[k], co, so);
            det = cn * so - co * sn;
            if (det == 0) continue;    // parallel sticks
            bx = sh_x[k] - nx;
            by = sh_y[k] - ny;
            num_o = bx * sn - cn * by;
            num_n = so * bx - co * by;
            if (det < 0) begin
                det = -det;
                num_o = -num_o;
                num_n = -num_n;
            end
            if (num_o <= 0 || num_n <= 0) continue;
            d_o = (num_o * 65536) / det;
            d_n = (num_n * 65536) / det;
            if (d_o <= 0 || d_o >= sh_length) continue;
            if (d_n <= 0 || d_n >= sh_length) continue;
            rec.old_slot  = k[spcf_pkg::SLOT_W-1:0];
            rec.new_slot  = slot[spcf_pkg::NSLOT_W-1:0];
            rec.old_label = sh_label[k];
            rec.new_label = st.label;
            rec.d_old     = d_o[spcf_pkg::DIST_W-1:0];
            rec.d_new     = d_n[spcf_pkg::DIST_W-1:0];
            rec.full      = full;
            rec.last      = 1'b0;
            crossing_q = {crossing_q, rec};
            n++;
        end
        if (n > 0) crossing_q[$].last = 1'b1;
        if (n == spcf_pkg::MAX_RES) n_capped++;
        if (full) n_full_records += n;
        if (!full) begin
            sh_x[slot]     = nx;
            sh_y[slot]     = ny;
            sh_angle[slot] = st.angle;
            sh_label[slot] = st.label;
            sh_count++;
        end
    endtask

    // monitor: input acceptance feeds the predictor, output beats are checked
    always @(posedge i_clk) begin
        t_crossing  want;
        t_crossing  got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d records still expected",
                     cycles, crossing_q.size());
            $display("simulation failed");
            $finish;
        end else begin
            s_taken <= i_s_tvalid && o_s_tready;
            if (i_rst_n && i_s_tvalid && o_s_tready) find_crossings(cur_stick);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got.old_slot  = o_m_tdata[5:0];
                got.new_slot  = o_m_tdata[12:6];
                got.old_label = o_m_tdata[28:13];
                got.new_label = o_m_tdata[44:29];
                got.d_old     = o_m_tdata[61:45];
                got.d_new     = o_m_tdata[78:62];
                got.full      = o_m_tuser;
                got.last      = o_m_tlast;
                n_records++;
                if (crossing_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected record: slots %0d/%0d labels %0d/%0d d %0d/%0d",
                                 got.old_slot, got.new_slot, got.old_label,
                                 got.new_label, got.d_old, got.d_new);
                end else begin
                    want = crossing_q.pop_front();
                    if (got != want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp slots %0d/%0d labels %0d/%0d d %0d/%0d ",
                                      "full %0b last %0b, got %0d/%0d %0d/%0d %0d/%0d %0b %0b"},
                                     want.old_slot, want.new_slot, want.old_label,
                                     want.new_label, want.d_old, want.d_new, want.full,
                                     want.last, got.old_slot, got.new_slot, got.old_label,
                                     got.new_label, got.d_old, got.d_new, got.full, got.last);
                    end
                end
            end
        end
    end

    // driver: one beat held until taken, random gaps between beats while idle_en is set
    int src_gap = 0;
    always @(negedge i_clk) begin
        logic   v_next;
        t_stick st;
        v_next = 1'b0;
        if (!i_rst_n) begin
            v_next = 1'b0;
        end else if (i_s_tvalid && !s_taken) begin
            v_next = 1'b1;
        end else if (src_gap > 0) begin
            src_gap--;
        end else if (stick_q.size() > 0) begin
            if (idle_en && $urandom_range(0, 5) == 0) begin
                src_gap = $urandom_range(1, 15) - 1;
            end else begin
                st = stick_q.pop_front();
                cur_stick <= st;
                i_s_tdata <= {4'b0, st.angle, st.py, st.px, st.label};
                i_s_tuser <= st.kind;
                v_next = 1'b1;
            end
        end
        i_s_tvalid <= v_next;
    end

    // receiver: random stalls while idle_en is set, plus one long hold-off once records flow on request
    int sink_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (hold_req && !hold_done && o_m_tvalid) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                i_m_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(1, 15) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic add_stick(input int lab, input int x, input int y, input int ang);
        t_stick st;
        st.kind  = spcf_pkg::KIND_ADD;
        st.label = lab[spcf_pkg::LAB_W-1:0];
        st.px    = x[spcf_pkg::POS_W-1:0];
        st.py    = y[spcf_pkg::POS_W-1:0];
        st.angle = ang[spcf_pkg::ANG_W-1:0];
        stick_q = {stick_q, st};
    endtask

    task automatic add_clear();
        t_stick st;
        st.kind  = spcf_pkg::KIND_CLEAR;
        st.label = $urandom();
        st.px    = $urandom();
        st.py    = $urandom();
        st.angle = $urandom();
        stick_q = {stick_q, st};
    endtask

    // all beats sent, all records seen, and the block past its longest silent item
    task automatic wait_quiet();
        do @(posedge i_clk);
        while (stick_q.size() != 0 || i_s_tvalid || crossing_q.size() != 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic set_length(input int len);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len[spcf_pkg::LEN_W-1:0];
        sh_length = len & 32'h1FFFF;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random sticks: mostly clustered so they cross, labels often reused
    task automatic random_sticks(input int count);
        int lab, x, y;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                add_clear();
            end else begin
                lab = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 65535);
                if ($urandom_range(0, 3) == 0) begin
                    x = $urandom_range(0, 196607) - 65536;
                    y = $urandom_range(0, 196607) - 65536;
                end else begin
                    x = $urandom_range(0, 65535);
                    y = $urandom_range(0, 65535);
                end
                add_stick(lab, x, y, $urandom_range(0, 65535));
            end
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: crossing pair, ghost skip, parallel, angle and position extremes
        add_stick(1, 0, 0, 8192);
        add_stick(2, 32768, 0, 24576);
        add_stick(1, 10000, -20000, 8192);
        add_stick(3, 0, 20000, 8192);
        add_stick(4, -65536, -65536, 0);
        add_stick(5, 131071, 131071, 32768);
        add_stick(6, 16384, -1, 16384);
        add_stick(7, 40000, 100, 49152);
        add_stick(65535, 20000, 30000, 65535);
        add_stick(0, 20000, 30000, 16383);
        add_stick(8, -1, 131071, 49151);
        add_clear();
        add_stick(9, 0, 0, 8192);
        add_stick(10, 65536, 65536, 40960);
        wait_quiet();

        // longest sticks; fill the store with parallel verticals, then cross them all
        set_length(131071);
        for (int k = 0; k < spcf_pkg::MAX_STICKS; k++)
            add_stick(100 + k, 100 + k * 1000, 0, 16384);
        hold_req = 1'b1;
        add_stick(200, 0, 30000, 0);
        add_stick(201, 0, 40000, 65000);
        wait_quiet();

        // no stick length at all: nothing can cross
        set_length(0);
        add_clear();
        add_stick(1, 0, 0, 8192);
        add_stick(2, 32768, 0, 24576);
        wait_quiet();
        set_length(1);
        add_stick(3, 16384, 0, 20000);
        wait_quiet();

        add_clear();
        set_length(65536);
        random_sticks(25);
        wait_quiet();
        set_length($urandom_range(1, 131071));
        random_sticks(25);
        wait_quiet();

        // final stretch at full rate
        idle_en = 1'b0;
        set_length(131071);
        random_sticks(25);
        wait_quiet();

        $display("%0d add and %0d clear beats, %0d crossing records checked",
                 n_adds, n_clears, n_records);
        $display("%0d records from a full store, %0d sticks hit the record cap",
                 n_full_records, n_capped);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", errors);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
